FILE: hdl/rbi_pkg.sv
package rbi_pkg;

   localparam int AXES = 3;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INV_DIR_X = 3'd0,
      CSR_INV_DIR_Y = 3'd1,
      CSR_INV_DIR_Z = 3'd2,
      CSR_DIR_X     = 3'd3,
      CSR_DIR_Y     = 3'd4,
      CSR_DIR_Z     = 3'd5
   } csr_index_type;

   // hit sits in bit 0, starts_inside in bit 1
   typedef struct packed {
      logic starts_inside;
      logic hit;
   } result_flags_type;

endpackage

FILE: hdl/rbi_csr.sv
module rbi_csr
   import rbi_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata,
   output logic signed [COORD_BITS-1:0] inv_dir [AXES],
   output logic signed [COORD_BITS-1:0] dir [AXES]
);

   logic signed [COORD_BITS-1:0] inv_dir_ff [AXES];
   logic signed [COORD_BITS-1:0] dir_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            inv_dir_ff[i] <= '0;
            dir_ff[i]     <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_DIR_X: inv_dir_ff[0] <= csr_wdata;
            CSR_INV_DIR_Y: inv_dir_ff[1] <= csr_wdata;
            CSR_INV_DIR_Z: inv_dir_ff[2] <= csr_wdata;
            CSR_DIR_X:     dir_ff[0]     <= csr_wdata;
            CSR_DIR_Y:     dir_ff[1]     <= csr_wdata;
            CSR_DIR_Z:     dir_ff[2]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign inv_dir = inv_dir_ff;
   assign dir     = dir_ff;

endmodule

FILE: hdl/rbi_slab.sv
module rbi_slab
   import rbi_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] box_min [AXES],
   input  logic signed [COORD_BITS-1:0] box_max [AXES],
   input  logic signed [COORD_BITS-1:0] origin [AXES],
   input  logic signed [COORD_BITS-1:0] inv_dir [AXES],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] t_out [AXES],
   output logic signed [COORD_BITS-1:0] plane_out [AXES],
   output logic signed [COORD_BITS-1:0] box_min_out [AXES],
   output logic signed [COORD_BITS-1:0] box_max_out [AXES],
   output logic signed [COORD_BITS-1:0] origin_out [AXES],
   output logic                         inside_out
);

   localparam int C  = COORD_BITS;
   localparam int PW = 2 * C + 2;
   localparam logic signed [C-1:0] NEG_ONE = {{(C-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};
   localparam logic signed [C-1:0] CMAX    = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] CMIN    = {1'b1, {(C-1){1'b0}}};

   function automatic logic signed [C-1:0] sat_shift(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      logic signed [C-1:0]  r;
      s = p >>> FRAC_BITS;
      if ((&s[PW-1:C-1]) || !(|s[PW-1:C-1])) r = s[C-1:0];
      else if (s[PW-1]) r = CMIN;
      else r = CMAX;
      return r;
   endfunction

   // stage 1: facing plane and offset to it
   logic                 s1_valid_ff;
   logic signed [C:0]    s1_diff_in [AXES];
   logic signed [C:0]    s1_diff_ff [AXES];
   logic signed [C-1:0]  s1_plane_in [AXES];
   logic signed [C-1:0]  s1_plane_ff [AXES];
   logic [AXES-1:0]      s1_out_in, s1_out_ff;
   logic [AXES-1:0]      s1_en_in, s1_en_ff;
   logic signed [C-1:0]  s1_min_ff [AXES];
   logic signed [C-1:0]  s1_max_ff [AXES];
   logic signed [C-1:0]  s1_org_ff [AXES];
   // stage 2: exact product
   logic                 s2_valid_ff;
   logic signed [PW-1:0] s2_prod_in [AXES];
   logic signed [PW-1:0] s2_prod_ff [AXES];
   logic signed [C-1:0]  s2_plane_ff [AXES];
   logic [AXES-1:0]      s2_out_ff, s2_en_ff;
   logic signed [C-1:0]  s2_min_ff [AXES];
   logic signed [C-1:0]  s2_max_ff [AXES];
   logic signed [C-1:0]  s2_org_ff [AXES];
   // stage 3: distance
   logic                 s3_valid_ff;
   logic signed [C-1:0]  s3_t_in [AXES];
   logic signed [C-1:0]  s3_t_ff [AXES];
   logic signed [C-1:0]  s3_plane_ff [AXES];
   logic                 s3_inside_ff;
   logic signed [C-1:0]  s3_min_ff [AXES];
   logic signed [C-1:0]  s3_max_ff [AXES];
   logic signed [C-1:0]  s3_org_ff [AXES];

   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         logic below, above;
         below          = origin[i] < box_min[i];
         above          = !below && (origin[i] > box_max[i]);
         s1_plane_in[i] = below ? box_min[i] : box_max[i];
         s1_out_in[i]   = below || above;
         s1_en_in[i]    = (below || above) && (inv_dir[i] != '0);
         s1_diff_in[i]  = (C+1)'(s1_plane_in[i]) - (C+1)'(origin[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         s2_prod_in[i] = PW'(s1_diff_ff[i]) * PW'(inv_dir[i]);
         s3_t_in[i]    = s2_en_ff[i] ? sat_shift(s2_prod_ff[i]) : NEG_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_diff_ff  <= s1_diff_in;
         s1_plane_ff <= s1_plane_in;
         s1_out_ff   <= s1_out_in;
         s1_en_ff    <= s1_en_in;
         s1_min_ff   <= box_min;
         s1_max_ff   <= box_max;
         s1_org_ff   <= origin;
      end
      if (s2_ready) begin
         s2_prod_ff  <= s2_prod_in;
         s2_plane_ff <= s1_plane_ff;
         s2_out_ff   <= s1_out_ff;
         s2_en_ff    <= s1_en_ff;
         s2_min_ff   <= s1_min_ff;
         s2_max_ff   <= s1_max_ff;
         s2_org_ff   <= s1_org_ff;
      end
      if (s3_ready) begin
         s3_t_ff      <= s3_t_in;
         s3_plane_ff  <= s2_plane_ff;
         s3_inside_ff <= !(|s2_out_ff);
         s3_min_ff    <= s2_min_ff;
         s3_max_ff    <= s2_max_ff;
         s3_org_ff    <= s2_org_ff;
      end
   end

   assign out_valid   = s3_valid_ff;
   assign t_out       = s3_t_ff;
   assign plane_out   = s3_plane_ff;
   assign box_min_out = s3_min_ff;
   assign box_max_out = s3_max_ff;
   assign origin_out  = s3_org_ff;
   assign inside_out  = s3_inside_ff;

endmodule

FILE: hdl/rbi_entry.sv
module rbi_entry
   import rbi_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] t_in [AXES],
   input  logic signed [COORD_BITS-1:0] plane_in [AXES],
   input  logic signed [COORD_BITS-1:0] box_min [AXES],
   input  logic signed [COORD_BITS-1:0] box_max [AXES],
   input  logic signed [COORD_BITS-1:0] origin [AXES],
   input  logic                         inside_in,
   input  logic signed [COORD_BITS-1:0] dir [AXES],
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output result_flags_type             flags,
   output logic signed [COORD_BITS-1:0] hit_coord [AXES]
);

   localparam int C  = COORD_BITS;
   localparam int PW = 2 * C;
   localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

   function automatic logic signed [C-1:0] sat_shift(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      logic signed [C-1:0]  r;
      s = p >>> FRAC_BITS;
      if ((&s[PW-1:C-1]) || !(|s[PW-1:C-1])) r = s[C-1:0];
      else if (s[PW-1]) r = CMIN;
      else r = CMAX;
      return r;
   endfunction

   function automatic logic signed [C-1:0] sat_sum(input logic signed [C:0] v);
      logic signed [C-1:0] r;
      if (v[C] == v[C-1]) r = v[C-1:0];
      else if (v[C]) r = CMIN;
      else r = CMAX;
      return r;
   endfunction

   // stage 4: entry axis select
   logic                 s4_valid_ff;
   logic [1:0]           s4_w_in, s4_w_ff;
   logic signed [C-1:0]  s4_tw_in, s4_tw_ff;
   logic signed [C-1:0]  s4_plane_ff [AXES];
   logic signed [C-1:0]  s4_min_ff [AXES];
   logic signed [C-1:0]  s4_max_ff [AXES];
   logic signed [C-1:0]  s4_org_ff [AXES];
   logic                 s4_inside_ff;
   // stage 5: projection products
   logic                 s5_valid_ff;
   logic signed [PW-1:0] s5_prod_in [AXES];
   logic signed [PW-1:0] s5_prod_ff [AXES];
   logic [1:0]           s5_w_ff;
   logic                 s5_tneg_ff;
   logic signed [C-1:0]  s5_plane_ff [AXES];
   logic signed [C-1:0]  s5_min_ff [AXES];
   logic signed [C-1:0]  s5_max_ff [AXES];
   logic signed [C-1:0]  s5_org_ff [AXES];
   logic                 s5_inside_ff;
   // stage 6: projected coordinates before final clamp
   logic                 s6_valid_ff;
   logic signed [C:0]    s6_proj_in [AXES];
   logic signed [C:0]    s6_proj_ff [AXES];
   logic [1:0]           s6_w_ff;
   logic                 s6_tneg_ff;
   logic signed [C-1:0]  s6_plane_ff [AXES];
   logic signed [C-1:0]  s6_min_ff [AXES];
   logic signed [C-1:0]  s6_max_ff [AXES];
   logic signed [C-1:0]  s6_org_ff [AXES];
   logic                 s6_inside_ff;
   // stage 7: box check and result
   logic                 s7_valid_ff;
   result_flags_type     s7_flags_in, s7_flags_ff;
   logic signed [C-1:0]  s7_coord_in [AXES];
   logic signed [C-1:0]  s7_coord_ff [AXES];

   logic s4_ready, s5_ready, s6_ready, s7_ready;

   assign s7_ready = !s7_valid_ff || rsp_ready;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_ready = s4_ready;

   // largest distance, lower axis on ties
   always_comb begin
      logic                c10;
      logic signed [C-1:0] t01;
      c10 = t_in[1] > t_in[0];
      t01 = c10 ? t_in[1] : t_in[0];
      if (t_in[2] > t01) begin
         s4_w_in  = 2'd2;
         s4_tw_in = t_in[2];
      end else begin
         s4_w_in  = c10 ? 2'd1 : 2'd0;
         s4_tw_in = t01;
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         s5_prod_in[i] = PW'(s4_tw_ff) * PW'(dir[i]);
         s6_proj_in[i] = (C+1)'(s5_org_ff[i]) + (C+1)'(sat_shift(s5_prod_ff[i]));
      end
   end

   always_comb begin
      logic                miss;
      logic signed [C-1:0] pt;
      miss = s6_tneg_ff;
      for (int i = 0; i < AXES; i++) begin
         pt = sat_sum(s6_proj_ff[i]);
         if (s6_w_ff == 2'(i)) begin
            s7_coord_in[i] = s6_plane_ff[i];
         end else begin
            s7_coord_in[i] = pt;
            if (pt < s6_min_ff[i] || pt > s6_max_ff[i]) miss = 1'b1;
         end
      end
      s7_flags_in.starts_inside = s6_inside_ff;
      s7_flags_in.hit           = s6_inside_ff || !miss;
      for (int i = 0; i < AXES; i++) begin
         if (s6_inside_ff) s7_coord_in[i] = s6_org_ff[i];
         else if (miss) s7_coord_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (s4_ready) s4_valid_ff <= in_valid;
         if (s5_ready) s5_valid_ff <= s4_valid_ff;
         if (s6_ready) s6_valid_ff <= s5_valid_ff;
         if (s7_ready) s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_w_ff      <= s4_w_in;
         s4_tw_ff     <= s4_tw_in;
         s4_plane_ff  <= plane_in;
         s4_min_ff    <= box_min;
         s4_max_ff    <= box_max;
         s4_org_ff    <= origin;
         s4_inside_ff <= inside_in;
      end
      if (s5_ready) begin
         s5_prod_ff   <= s5_prod_in;
         s5_w_ff      <= s4_w_ff;
         s5_tneg_ff   <= s4_tw_ff[C-1];
         s5_plane_ff  <= s4_plane_ff;
         s5_min_ff    <= s4_min_ff;
         s5_max_ff    <= s4_max_ff;
         s5_org_ff    <= s4_org_ff;
         s5_inside_ff <= s4_inside_ff;
      end
      if (s6_ready) begin
         s6_proj_ff   <= s6_proj_in;
         s6_w_ff      <= s5_w_ff;
         s6_tneg_ff   <= s5_tneg_ff;
         s6_plane_ff  <= s5_plane_ff;
         s6_min_ff    <= s5_min_ff;
         s6_max_ff    <= s5_max_ff;
         s6_org_ff    <= s5_org_ff;
         s6_inside_ff <= s5_inside_ff;
      end
      if (s7_ready) begin
         s7_flags_ff <= s7_flags_in;
         s7_coord_ff <= s7_coord_in;
      end
   end

   assign rsp_valid = s7_valid_ff;
   assign flags     = s7_flags_ff;
   assign hit_coord = s7_coord_ff;

`ifndef SYNTHESIS
   a_inside_is_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && flags.starts_inside |-> flags.hit)
      else $error("starts_inside without hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !flags.hit |->
         hit_coord[0] == '0 && hit_coord[1] == '0 && hit_coord[2] == '0)
      else $error("miss with nonzero coordinates");

   a_axis_code: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s4_w_ff != 2'd3)
      else $error("entry axis out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s6_valid_ff && !s7_ready |=> s6_valid_ff && $stable(s6_w_ff) && $stable(s6_tneg_ff))
      else $error("stage 6 changed while stalled");
`endif

endmodule

FILE: hdl/ray_box_intersect_unit.sv
// Ray versus axis-aligned box test, signed fixed point.
//
// csr_*: write port for inv_dir_x/y/z (index 0..2) and dir_x/y/z (3..5);
//   a write takes effect on the edge where csr_wr_en is high, other
//   indexes are dropped. Write only while no transaction is in flight.
// req_*: one box test per transaction: box min corner, box max corner and
//   ray origin, each COORD_BITS signed with FRAC_BITS fraction bits.
// rsp_*: one result per request, in order: hit and starts_inside flags in
//   rsp_tuser, entry point in rsp_tdata (origin when inside, zero on miss).
//
// Seven register stages: plane select, slab product, distance clamp, entry
// axis select, projection products, projection sum, box check. Throughput
// is one transaction per cycle while rsp_tready is not held low; the two
// multiplier stages work on successive items.
// Each stage holds its own valid bit, so a stalled rsp_tready backs up only
// the stages that are full; bubbles are squeezed out and req_tready drops
// once all seven stages hold data.
// Reset clears the direction registers to zero and empties the pipeline.
module ray_box_intersect_unit
   import rbi_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]          csr_index,
   input  logic [COORD_BITS-1:0]              csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
   // origin_x, origin_y, origin_z
   input  logic [((9*COORD_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit_x, hit_y, hit_z
   output logic [((3*COORD_BITS+7)/8)*8-1:0]  rsp_tdata,
   // hit, starts_inside
   output logic [1:0]                         rsp_tuser
);

   localparam int C        = COORD_BITS;

   logic signed [C-1:0] inv_dir [AXES];
   logic signed [C-1:0] dir [AXES];
   logic signed [C-1:0] box_min [AXES];
   logic signed [C-1:0] box_max [AXES];
   logic signed [C-1:0] origin [AXES];

   logic                slab_valid, slab_ready;
   logic signed [C-1:0] slab_t [AXES];
   logic signed [C-1:0] slab_plane [AXES];
   logic signed [C-1:0] slab_min [AXES];
   logic signed [C-1:0] slab_max [AXES];
   logic signed [C-1:0] slab_org [AXES];
   logic                slab_inside;

   result_flags_type    flags;
   logic signed [C-1:0] hit_coord [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         box_min[i] = req_tdata[i*C +: C];
         box_max[i] = req_tdata[(AXES+i)*C +: C];
         origin[i]  = req_tdata[(2*AXES+i)*C +: C];
      end
   end

   rbi_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .inv_dir   (inv_dir),
      .dir       (dir)
   );

   rbi_slab #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_slab (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .box_min     (box_min),
      .box_max     (box_max),
      .origin      (origin),
      .inv_dir     (inv_dir),
      .out_valid   (slab_valid),
      .out_ready   (slab_ready),
      .t_out       (slab_t),
      .plane_out   (slab_plane),
      .box_min_out (slab_min),
      .box_max_out (slab_max),
      .origin_out  (slab_org),
      .inside_out  (slab_inside)
   );

   rbi_entry #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_entry (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (slab_valid),
      .in_ready  (slab_ready),
      .t_in      (slab_t),
      .plane_in  (slab_plane),
      .box_min   (slab_min),
      .box_max   (slab_max),
      .origin    (slab_org),
      .inside_in (slab_inside),
      .dir       (dir),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .flags     (flags),
      .hit_coord (hit_coord)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < AXES; i++) begin
         rsp_tdata[i*C +: C] = hit_coord[i];
      end
   end

   assign rsp_tuser = {flags.starts_inside, flags.hit};

endmodule
